// ===== rtl/core/block_claim_bitmap_reconcile_top_assert.svh =====
// Assertion macros shared by the block claim bitmap reconcile RTL.
`ifndef BLOCK_CLAIM_BITMAP_RECONCILE_TOP_ASSERT_SVH
`define BLOCK_CLAIM_BITMAP_RECONCILE_TOP_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define BCBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds across reset.
`define BCBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/bcbr_pkg.sv =====
// Package: constants, codes and controller/datapath interface types.
package bcbr_pkg;

  localparam int MAX_BLOCKS = 65536;

  // Referenced map organized as rows of bits
  localparam int ROW_W     = 32;
  localparam int ROW_SEL_W = $clog2(ROW_W);
  localparam int MAP_ROWS  = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  localparam int BLK_W  = 32;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W = 3;

  localparam logic [BLK_W-1:0] MAX_BLOCKS_B = BLK_W'(MAX_BLOCKS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPAIR_ENABLE    = 2'd2;

  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(65536);

  // Commands
  localparam logic CMD_CLAIM   = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_CLAIMED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_AGREES    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING   = 3'd4;
  localparam logic [STAT_W-1:0] ST_LEAKED    = 3'd5;

  typedef struct packed {
    logic clr_en;  // clear one map row
    logic load;    // capture transaction, read map row
    logic exec;    // update map, counters and result
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing the last map row
  } dp_stat_t;

endpackage

// ===== rtl/core/bcbr_ctrl.sv =====
// Controller FSM: map clearing pass, idle and execute sequencing.
`include "block_claim_bitmap_reconcile_top_assert.svh"

module bcbr_ctrl
  import bcbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign cmd_o.clr_en = (state_q == S_CLEAR);
  assign cmd_o.load   = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec   = (state_q == S_EXEC);

  `BCBR_ASSERT_RST(a_rst_clear, !rst_ni |=> state_q == S_CLEAR, "reset must start clearing")
  `BCBR_ASSERT(a_accept_exec, (start_i && !busy_o) |=> state_q == S_EXEC,
               "accepted transaction must execute next")
  `BCBR_ASSERT(a_exec_one, state_q == S_EXEC |=> state_q == S_IDLE, "execute lasts one cycle")
  `BCBR_ASSERT(a_clear_hold, (state_q == S_CLEAR && !stat_i.clr_last) |=> state_q == S_CLEAR,
               "clearing pass left early")

endmodule

// ===== rtl/core/bcbr_dp.sv =====
// Datapath: config registers, referenced map memory, checks, counters, result.
`include "block_claim_bitmap_reconcile_top_assert.svh"

module bcbr_dp
  import bcbr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 command_i,
  input  logic [BLK_W-1:0]     block_i,
  input  logic                 marked_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic                 used_o,
  output logic                 corrected_mark_o,
  output logic [CNT_W-1:0]     bad_pointer_total_o,
  output logic [CNT_W-1:0]     duplicate_total_o,
  output logic [CNT_W-1:0]     missing_total_o,
  output logic [CNT_W-1:0]     leaked_total_o
);

  // Config
  logic [CFG_W-1:0] fdb_q, bc_q;
  logic             rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q <= '0;
      bc_q  <= BLOCK_COUNT_RST;
      rep_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIRST_DATA_BLOCK: fdb_q <= cfg_data_i;
        REG_BLOCK_COUNT:      bc_q  <= cfg_data_i;
        REG_REPAIR_ENABLE:    rep_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured transaction
  logic             cmd_q, mark_q;
  logic [BLK_W-1:0] blk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      blk_q  <= block_i;
      mark_q <= marked_i;
    end
  end

  // Clear pointer
  logic [ROW_AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + ROW_AW'(1);
    end
  end

  assign stat_o.clr_last = (clr_q == ROW_AW'(MAP_ROWS - 1));

  // Map memory: read on load, write on exec or clear
  logic [ROW_W-1:0]  map_mem [MAP_ROWS];
  logic [ROW_W-1:0]  row_q, wr_data;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic              wr_en;

  assign rd_addr = block_i[ROW_SEL_W +: ROW_AW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) row_q <= map_mem[rd_addr];
    if (wr_en) map_mem[wr_addr] <= wr_data;
  end

  // Checks
  logic [BLK_W-1:0] img_size;
  logic in_img, below, bit_set, blk_used;
  logic do_set;
  logic [ROW_SEL_W-1:0] bit_sel;

  assign img_size = ({{(BLK_W-CFG_W){1'b0}}, bc_q} > MAX_BLOCKS_B) ? MAX_BLOCKS_B
                  : {{(BLK_W-CFG_W){1'b0}}, bc_q};
  assign in_img   = blk_q < img_size;
  assign below    = blk_q < {{(BLK_W-CFG_W){1'b0}}, fdb_q};
  assign bit_sel  = blk_q[ROW_SEL_W-1:0];
  assign bit_set  = row_q[bit_sel];
  assign blk_used = in_img && (below || bit_set);
  assign do_set   = cmd_i.exec && (cmd_q == CMD_CLAIM) && in_img && !below && !bit_set;

  always_comb begin
    wr_en   = cmd_i.clr_en || do_set;
    wr_addr = cmd_i.clr_en ? clr_q : blk_q[ROW_SEL_W +: ROW_AW];
    wr_data = cmd_i.clr_en ? '0 : (row_q | (ROW_W'(1) << bit_sel));
  end

  // Result and counter updates
  logic [STAT_W-1:0] status_d;
  logic              used_d, corr_d;
  logic              inc_bad, inc_dup, inc_mis, inc_leak;

  always_comb begin
    status_d = ST_OUTSIDE;
    used_d   = 1'b0;
    corr_d   = 1'b0;
    inc_bad  = 1'b0;
    inc_dup  = 1'b0;
    inc_mis  = 1'b0;
    inc_leak = 1'b0;
    if (cmd_q == CMD_CLAIM) begin
      if (below || !in_img) begin
        status_d = ST_OUTSIDE;
        used_d   = blk_used;
        inc_bad  = 1'b1;
      end else if (bit_set) begin
        status_d = ST_DUPLICATE;
        used_d   = 1'b1;
        inc_dup  = 1'b1;
      end else begin
        status_d = ST_CLAIMED;
        used_d   = 1'b1;
      end
    end else if (!in_img) begin
      status_d = ST_OUTSIDE;
      corr_d   = mark_q;
    end else begin
      used_d = blk_used;
      corr_d = rep_q ? blk_used : mark_q;
      if (blk_used == mark_q) begin
        status_d = ST_AGREES;
      end else if (blk_used) begin
        status_d = ST_MISSING;
        inc_mis  = 1'b1;
      end else begin
        status_d = ST_LEAKED;
        inc_leak = 1'b1;
      end
    end
  end

  logic [CNT_W-1:0] bad_q, dup_q, mis_q, leak_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q  <= '0;
      dup_q  <= '0;
      mis_q  <= '0;
      leak_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        if (inc_bad && bad_q != '1) bad_q <= bad_q + CNT_W'(1);
        if (inc_dup && dup_q != '1) dup_q <= dup_q + CNT_W'(1);
        if (inc_mis && mis_q != '1) mis_q <= mis_q + CNT_W'(1);
        if (inc_leak && leak_q != '1) leak_q <= leak_q + CNT_W'(1);
      end
    end
  end

  logic [STAT_W-1:0] status_q;
  logic              used_q, corr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      used_q   <= used_d;
      corr_q   <= corr_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign used_o              = used_q;
  assign corrected_mark_o    = corr_q;
  assign bad_pointer_total_o = bad_q;
  assign duplicate_total_o   = dup_q;
  assign missing_total_o     = mis_q;
  assign leaked_total_o      = leak_q;

  `BCBR_ASSERT(a_bad_monotonic, bad_q >= $past(bad_q), "bad pointer counter went down")
  `BCBR_ASSERT(a_dup_counted,
               (done_q && status_q == ST_DUPLICATE) |-> (dup_q != $past(dup_q) || dup_q == '1),
               "duplicate result without count")
  `BCBR_ASSERT(a_done_after_exec, cmd_i.exec |=> done_q, "result strobe missing after execute")

endmodule

// ===== rtl/core/block_claim_bitmap_reconcile_top.sv =====
// Top level of the block claim bitmap reconcile unit.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+----------------------------------
//  command  | command_i, block_i, marked_i              | start_i & !busy_o
//  result   | status_o, used_o, corrected_mark_o, *_o   | done_o, one cycle, no back-pressure
//  config   | cfg_index_i, cfg_data_i                   | cfg_valid_i & cfg_ready_o
//
// Each transaction is a read-modify-write: the map row is read at the accepting edge,
// then updated and written back on the next; the result shows with done_o in
// the cycle after that, while busy_o is already low again.
// busy_o holds off a new command during the read-modify-write of one map memory row.
// After reset a clearing pass zeroes the map, one 32-bit row a cycle
// (MAX_BLOCKS/32 = 2048 rows); busy_o stays high and no command is taken,
// config writes are. The result receiver cannot stall.
module block_claim_bitmap_reconcile_top
  import bcbr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 command_i,
  input  logic [BLK_W-1:0]     block_i,
  input  logic                 marked_i,
  // result channel
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic                 used_o,
  output logic                 corrected_mark_o,
  output logic [CNT_W-1:0]     bad_pointer_total_o,
  output logic [CNT_W-1:0]     duplicate_total_o,
  output logic [CNT_W-1:0]     missing_total_o,
  output logic [CNT_W-1:0]     leaked_total_o,
  // config channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Config registers always take a write
  assign cfg_ready_o = 1'b1;

  bcbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy_o)
  );

  bcbr_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (command_i),
    .block_i             (block_i),
    .marked_i            (marked_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .used_o              (used_o),
    .corrected_mark_o    (corrected_mark_o),
    .bad_pointer_total_o (bad_pointer_total_o),
    .duplicate_total_o   (duplicate_total_o),
    .missing_total_o     (missing_total_o),
    .leaked_total_o      (leaked_total_o)
  );

endmodule
